/* src/e2e_pkg.sv */
// Shared types, constants and the arctangent table for the ecliptic to equatorial converter.
package e2e_pkg;

    // Number of CORDIC iterations in each rotation and vectoring chain.
    localparam int CORDIC_STAGES = 24;
    localparam int STAGE_IDX_W = 5;

    // One digit pair of the square root per cell: 32 result bits.
    localparam int SQRT_STEPS = 32;

    // Internal word widths.
    localparam int RW = 50;   // rotation operands, Q8.40
    localparam int EW = 34;   // residual obliquity angle
    localparam int CW = 34;   // rotated components back in Q8.24
    localparam int VW = 66;   // vectoring operands, scaled by 2^28
    localparam int SQW = 64;  // squared magnitudes
    localparam int REMW = 34; // square root remainder

    // Fixed-point constants.
    localparam logic signed [EW-1:0] OBL_BASE = 34'sd279641634;
    localparam logic signed [40:0] OBL_RATE = 41'sd278375;
    localparam logic signed [64:0] INV_GAIN = 65'sd2608131496;
    localparam int FRAC_EXTRA = 16;
    localparam int ANGLE_SCALE = 28;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    typedef struct packed {
        logic signed [RW-1:0] y;
        logic signed [RW-1:0] z;
        logic signed [EW-1:0] eps;
    } rot_t;

    typedef struct packed {
        logic [SQW-1:0] rad;
        logic [REMW-1:0] rem;
        logic [31:0] root;
    } sqrt_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic [31:0] ang;
    } vec_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [CW-1:0] y24;
        logic signed [CW-1:0] z24;
    } side_t;

    typedef struct packed {
        logic [31:0] dst;
        logic status;
        logic ra_zero;
        logic dec_zero;
    } info_t;

    typedef struct packed {
        logic [31:0] ra;
        logic [31:0] dec;
        logic [31:0] dst;
        logic status;
    } res_t;

    // Arctangent of 2^-k in units of 2^-32 turn.
    function automatic logic [31:0] atan_lut(input logic [STAGE_IDX_W-1:0] k);
        logic [31:0] v;
        case (k)
            5'd0: v = 32'h20000000;
            5'd1: v = 32'h12E4051E;
            5'd2: v = 32'h09FB385B;
            5'd3: v = 32'h051111D4;
            5'd4: v = 32'h028B0D43;
            5'd5: v = 32'h0145D7E1;
            5'd6: v = 32'h00A2F61E;
            5'd7: v = 32'h00517C55;
            5'd8: v = 32'h0028BE53;
            5'd9: v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

/* src/ecliptic_to_equatorial.sv */
// Top level of the ecliptic to equatorial converter: pipeline of CORDIC and square-root cells.
// Accepts one transaction per cycle while in_ready is high; a skid register at the output
// keeps the pipeline full under stall, and in_ready drops only while that skid register
// holds a result. Reset (rst_n low, asynchronous) empties the pipeline and the output stage
// and sets min_distance to 1; no clearing pass is needed.
module ecliptic_to_equatorial (
    input  logic clk,
    input  logic rst_n,
    input  logic min_distance_wr_en,
    input  logic [24:0] min_distance_wr_data,
    input  logic in_valid,
    output logic in_ready,
    input  logic signed [31:0] ecl_x,
    input  logic signed [31:0] ecl_y,
    input  logic signed [31:0] ecl_z,
    input  logic signed [20:0] days_since_epoch,
    output logic out_valid,
    input  logic out_ready,
    output logic [31:0] ra_angle,
    output logic signed [31:0] declination,
    output logic [31:0] distance,
    output logic status
);

    localparam int NR = e2e_pkg::CORDIC_STAGES;
    localparam int NS = e2e_pkg::SQRT_STEPS;
    localparam int NV = 2 * NR + NS + 6;
    localparam int RW = e2e_pkg::RW;
    localparam int CW = e2e_pkg::CW;
    localparam int VW = e2e_pkg::VW;
    localparam int SQW = e2e_pkg::SQW;

    logic en;
    logic [NV-1:0] v_reg;
    logic [24:0] min_distance_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_distance_reg <= 25'd1;
        end
        else if (min_distance_wr_en)
        begin
            min_distance_reg <= min_distance_wr_data;
        end
    end

    // Valid bits move with the data whenever the pipeline advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NV-2:0], in_valid};
        end
    end

    // Input stage: gain compensation products and the obliquity angle.
    logic signed [64:0] prod_y;
    logic signed [64:0] prod_z;
    logic signed [40:0] obl_prod;
    logic signed [40:0] obl_shift;
    e2e_pkg::rot_t a_rot_next;
    e2e_pkg::rot_t a_rot_reg;
    logic signed [31:0] a_x_reg;

    always_comb
    begin
        prod_y = 65'(ecl_y) * e2e_pkg::INV_GAIN;
        prod_z = 65'(ecl_z) * e2e_pkg::INV_GAIN;
        obl_prod = 41'(days_since_epoch) * e2e_pkg::OBL_RATE;
        obl_shift = (obl_prod + 41'sd32768) >>> 16;
        a_rot_next.y = RW'(prod_y >>> (32 - e2e_pkg::FRAC_EXTRA));
        a_rot_next.z = RW'(prod_z >>> (32 - e2e_pkg::FRAC_EXTRA));
        a_rot_next.eps = e2e_pkg::OBL_BASE - e2e_pkg::EW'(obl_shift);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_rot_reg <= a_rot_next;
            a_x_reg <= ecl_x;
        end
    end

    // Rotation chain about the x axis, with x carried alongside.
    e2e_pkg::rot_t rot_q [NR];
    logic signed [31:0] rot_x_reg [NR];

    for (genvar i = 0; i < NR; i++)
    begin : g_rot
        if (i == 0)
        begin : g_first
            e2e_rot_cell u_cell (
                .clk(clk), .en(en), .k(e2e_pkg::STAGE_IDX_W'(i)),
                .d(a_rot_reg), .q(rot_q[i])
            );
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rot_x_reg[i] <= a_x_reg;
                end
            end
        end
        else
        begin : g_rest
            e2e_rot_cell u_cell (
                .clk(clk), .en(en), .k(e2e_pkg::STAGE_IDX_W'(i)),
                .d(rot_q[i-1]), .q(rot_q[i])
            );
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rot_x_reg[i] <= rot_x_reg[i-1];
                end
            end
        end
    end

    // Round the rotated components back to Q8.24.
    localparam logic signed [RW-1:0] HALF_LSB = RW'(1) <<< (e2e_pkg::FRAC_EXTRA - 1);
    e2e_pkg::side_t b_side_reg;
    logic signed [RW-1:0] y_rot;
    logic signed [RW-1:0] z_rot;

    always_comb
    begin
        y_rot = rot_q[NR-1].y;
        z_rot = rot_q[NR-1].z;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_side_reg.x <= rot_x_reg[NR-1];
            b_side_reg.y24 <= CW'((y_rot + HALF_LSB) >>> e2e_pkg::FRAC_EXTRA);
            b_side_reg.z24 <= CW'((z_rot + HALF_LSB) >>> e2e_pkg::FRAC_EXTRA);
        end
    end

    // Squares of the equatorial components.
    e2e_pkg::side_t c_side_reg;
    logic [SQW-1:0] c_sx_reg;
    logic [SQW-1:0] c_sy_reg;
    logic [SQW-1:0] c_sz_reg;
    logic signed [63:0] sq_x;
    logic signed [2*CW-1:0] sq_y;
    logic signed [2*CW-1:0] sq_z;

    always_comb
    begin
        sq_x = 64'(b_side_reg.x) * 64'(b_side_reg.x);
        sq_y = (2*CW)'(b_side_reg.y24) * (2*CW)'(b_side_reg.y24);
        sq_z = (2*CW)'(b_side_reg.z24) * (2*CW)'(b_side_reg.z24);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_side_reg <= b_side_reg;
            c_sx_reg <= sq_x;
            c_sy_reg <= sq_y[SQW-1:0];
            c_sz_reg <= sq_z[SQW-1:0];
        end
    end

    // Sum of squares in the equatorial plane, then with z added.
    e2e_pkg::side_t d_side_reg;
    logic [SQW-1:0] d_sxy_reg;
    logic [SQW-1:0] d_sz_reg;
    e2e_pkg::side_t e_side_reg;
    e2e_pkg::sqrt_t e_rho_reg;
    e2e_pkg::sqrt_t e_dst_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_side_reg <= c_side_reg;
            d_sxy_reg <= c_sx_reg + c_sy_reg;
            d_sz_reg <= c_sz_reg;
            e_side_reg <= d_side_reg;
            e_rho_reg.rad <= d_sxy_reg;
            e_rho_reg.rem <= '0;
            e_rho_reg.root <= '0;
            e_dst_reg.rad <= d_sxy_reg + d_sz_reg;
            e_dst_reg.rem <= '0;
            e_dst_reg.root <= '0;
        end
    end

    // Square root chains for rho and distance, components carried alongside.
    e2e_pkg::sqrt_t sq_rho [NS];
    e2e_pkg::sqrt_t sq_dst [NS];
    e2e_pkg::side_t sq_side_reg [NS];

    for (genvar j = 0; j < NS; j++)
    begin : g_sqrt
        if (j == 0)
        begin : g_first
            e2e_sqrt_cell u_rho (.clk(clk), .en(en), .d(e_rho_reg), .q(sq_rho[j]));
            e2e_sqrt_cell u_dst (.clk(clk), .en(en), .d(e_dst_reg), .q(sq_dst[j]));
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_side_reg[j] <= e_side_reg;
                end
            end
        end
        else
        begin : g_rest
            e2e_sqrt_cell u_rho (.clk(clk), .en(en), .d(sq_rho[j-1]), .q(sq_rho[j]));
            e2e_sqrt_cell u_dst (.clk(clk), .en(en), .d(sq_dst[j-1]), .q(sq_dst[j]));
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_side_reg[j] <= sq_side_reg[j-1];
                end
            end
        end
    end

    // Vectoring set-up: scale, fold the left half-plane, flag zero vectors and short ones.
    e2e_pkg::side_t s_last;
    logic [31:0] rho;
    logic [31:0] dst_root;
    logic signed [VW-1:0] ra_x0;
    logic signed [VW-1:0] ra_y0;
    logic signed [VW-1:0] dec_x0;
    logic signed [VW-1:0] dec_y0;
    e2e_pkg::vec_t f_ra_next;
    e2e_pkg::vec_t f_dec_next;
    e2e_pkg::info_t f_info_next;
    e2e_pkg::vec_t f_ra_reg;
    e2e_pkg::vec_t f_dec_reg;
    e2e_pkg::info_t f_info_reg;

    always_comb
    begin
        s_last = sq_side_reg[NS-1];
        rho = sq_rho[NS-1].root;
        dst_root = sq_dst[NS-1].root;
        ra_x0 = VW'(s_last.x) <<< e2e_pkg::ANGLE_SCALE;
        ra_y0 = VW'(s_last.y24) <<< e2e_pkg::ANGLE_SCALE;
        dec_x0 = VW'(rho) <<< e2e_pkg::ANGLE_SCALE;
        dec_y0 = VW'(s_last.z24) <<< e2e_pkg::ANGLE_SCALE;
        if (ra_x0[VW-1])
        begin
            f_ra_next.x = -ra_x0;
            f_ra_next.y = -ra_y0;
            f_ra_next.ang = e2e_pkg::HALF_TURN;
        end
        else
        begin
            f_ra_next.x = ra_x0;
            f_ra_next.y = ra_y0;
            f_ra_next.ang = '0;
        end
        f_dec_next.x = dec_x0;
        f_dec_next.y = dec_y0;
        f_dec_next.ang = '0;
        f_info_next.dst = dst_root;
        f_info_next.status = dst_root < 32'(min_distance_reg);
        f_info_next.ra_zero = (s_last.x == '0) && (s_last.y24 == '0);
        f_info_next.dec_zero = (rho == '0) && (s_last.z24 == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_ra_reg <= f_ra_next;
            f_dec_reg <= f_dec_next;
            f_info_reg <= f_info_next;
        end
    end

    // Vectoring chains for right ascension and declination.
    e2e_pkg::vec_t vra_q [NR];
    e2e_pkg::vec_t vdec_q [NR];
    e2e_pkg::info_t vinfo_reg [NR];

    for (genvar i = 0; i < NR; i++)
    begin : g_vec
        if (i == 0)
        begin : g_first
            e2e_vec_cell u_ra (
                .clk(clk), .en(en), .k(e2e_pkg::STAGE_IDX_W'(i)),
                .d(f_ra_reg), .q(vra_q[i])
            );
            e2e_vec_cell u_dec (
                .clk(clk), .en(en), .k(e2e_pkg::STAGE_IDX_W'(i)),
                .d(f_dec_reg), .q(vdec_q[i])
            );
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    vinfo_reg[i] <= f_info_reg;
                end
            end
        end
        else
        begin : g_rest
            e2e_vec_cell u_ra (
                .clk(clk), .en(en), .k(e2e_pkg::STAGE_IDX_W'(i)),
                .d(vra_q[i-1]), .q(vra_q[i])
            );
            e2e_vec_cell u_dec (
                .clk(clk), .en(en), .k(e2e_pkg::STAGE_IDX_W'(i)),
                .d(vdec_q[i-1]), .q(vdec_q[i])
            );
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    vinfo_reg[i] <= vinfo_reg[i-1];
                end
            end
        end
    end

    // Result assembly: short vectors and zero vectors report zero angles.
    e2e_pkg::res_t res_new;
    e2e_pkg::info_t info_last;
    logic pipe_out_valid;

    always_comb
    begin
        info_last = vinfo_reg[NR-1];
        res_new.ra = (info_last.status || info_last.ra_zero) ? '0 : vra_q[NR-1].ang;
        res_new.dec = (info_last.status || info_last.dec_zero) ? '0 : vdec_q[NR-1].ang;
        res_new.dst = info_last.dst;
        res_new.status = info_last.status;
        pipe_out_valid = v_reg[NV-1] && en;
    end

    // Output register with a skid register behind it.
    logic out_valid_reg;
    logic skid_full_reg;
    e2e_pkg::res_t out_res_reg;
    e2e_pkg::res_t skid_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_full_reg)
            begin
                out_valid_reg <= 1'b1;
                skid_full_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= pipe_out_valid;
            end
        end
        else if (pipe_out_valid)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_full_reg)
            begin
                out_res_reg <= skid_res_reg;
            end
            else if (pipe_out_valid)
            begin
                out_res_reg <= res_new;
            end
        end
        else if (pipe_out_valid)
        begin
            skid_res_reg <= res_new;
        end
    end

    assign en = !skid_full_reg;
    assign in_ready = en;
    assign out_valid = out_valid_reg;
    assign ra_angle = out_res_reg.ra;
    assign declination = out_res_reg.dec;
    assign distance = out_res_reg.dst;
    assign status = out_res_reg.status;

endmodule

/* src/e2e_rot_cell.sv */
// One rotation-mode CORDIC iteration that turns the y/z pair towards the obliquity.
module e2e_rot_cell (
    input  logic clk,
    input  logic en,
    input  logic [e2e_pkg::STAGE_IDX_W-1:0] k,
    input  e2e_pkg::rot_t d,
    output e2e_pkg::rot_t q
);

    e2e_pkg::rot_t q_reg;
    e2e_pkg::rot_t q_next;
    logic signed [e2e_pkg::RW-1:0] y_in;
    logic signed [e2e_pkg::RW-1:0] z_in;
    logic signed [e2e_pkg::EW-1:0] eps_in;
    logic signed [e2e_pkg::EW-1:0] step;

    // Rotate by plus or minus atan(2^-k) according to the sign of the residual angle.
    always_comb
    begin
        y_in = d.y;
        z_in = d.z;
        eps_in = d.eps;
        step = $signed({2'b00, e2e_pkg::atan_lut(k)});
        if (!eps_in[e2e_pkg::EW-1])
        begin
            q_next.y = y_in - (z_in >>> k);
            q_next.z = z_in + (y_in >>> k);
            q_next.eps = eps_in - step;
        end
        else
        begin
            q_next.y = y_in + (z_in >>> k);
            q_next.z = z_in - (y_in >>> k);
            q_next.eps = eps_in + step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

/* src/e2e_sqrt_cell.sv */
// One digit step of the integer square root: takes the next two radicand bits.
module e2e_sqrt_cell (
    input  logic clk,
    input  logic en,
    input  e2e_pkg::sqrt_t d,
    output e2e_pkg::sqrt_t q
);

    e2e_pkg::sqrt_t q_reg;
    e2e_pkg::sqrt_t q_next;
    logic [e2e_pkg::REMW+1:0] part;
    logic [e2e_pkg::REMW+1:0] trial;

    // Bring down two bits and subtract 4*root+1 when it fits.
    always_comb
    begin
        part = {d.rem, d.rad[e2e_pkg::SQW-1 -: 2]};
        trial = (e2e_pkg::REMW+2)'({d.root, 2'b01});
        q_next.rad = d.rad << 2;
        if (part >= trial)
        begin
            q_next.rem = e2e_pkg::REMW'(part - trial);
            q_next.root = {d.root[30:0], 1'b1};
        end
        else
        begin
            q_next.rem = part[e2e_pkg::REMW-1:0];
            q_next.root = {d.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

/* src/e2e_vec_cell.sv */
// One vectoring-mode CORDIC iteration that drives y to zero and accumulates the angle.
module e2e_vec_cell (
    input  logic clk,
    input  logic en,
    input  logic [e2e_pkg::STAGE_IDX_W-1:0] k,
    input  e2e_pkg::vec_t d,
    output e2e_pkg::vec_t q
);

    e2e_pkg::vec_t q_reg;
    e2e_pkg::vec_t q_next;
    logic signed [e2e_pkg::VW-1:0] x_in;
    logic signed [e2e_pkg::VW-1:0] y_in;

    // A strictly positive y turns the vector clockwise, anything else anticlockwise.
    always_comb
    begin
        x_in = d.x;
        y_in = d.y;
        if (!y_in[e2e_pkg::VW-1] && (y_in != '0))
        begin
            q_next.x = x_in + (y_in >>> k);
            q_next.y = y_in - (x_in >>> k);
            q_next.ang = d.ang + e2e_pkg::atan_lut(k);
        end
        else
        begin
            q_next.x = x_in - (y_in >>> k);
            q_next.y = y_in + (x_in >>> k);
            q_next.ang = d.ang - e2e_pkg::atan_lut(k);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

/* src/e2e_checker.sv */
// Port-level checks for the ecliptic to equatorial converter, bound to the top level.
module e2e_checker (
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [31:0] ra_angle,
    input logic signed [31:0] declination,
    input logic [31:0] distance,
    input logic status
);

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ra_angle)
            && $stable(declination) && $stable(distance) && $stable(status))
        else $error("output transaction changed while stalled");

    // A short vector reports zero angles.
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> ra_angle == '0 && declination == '0)
        else $error("angles not zero on short vector");

    // Input back-pressure appears only after the output was stalled.
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready))
        else $error("in_ready dropped without output stall");

    // Back-pressure lasts no longer than the output stall that caused it.
    a_ready_back: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready && out_ready |=> in_ready)
        else $error("in_ready did not return after output taken");

endmodule

bind ecliptic_to_equatorial e2e_checker u_e2e_checker (.*);
